FILE: rtl/assert_macros.svh
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds on every clock edge outside reset.
`define HWT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HWT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/hwt_pkg.sv
`default_nettype none
package hwt_pkg;

    localparam int MAX_WORD_LEN   = 32;
    localparam int TAG_PREFIX_LEN = 8;

    localparam int WLEN_W  = $clog2(MAX_WORD_LEN + 2);
    localparam int WADDR_W = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
    localparam int TCNT_W  = $clog2(TAG_PREFIX_LEN + 1);
    localparam int TIDX_W  = $clog2(TAG_PREFIX_LEN);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int POS_W      = 32;
    localparam int DOC_W      = 32;
    localparam int STY_W      = 4;
    localparam int CHAR_W     = 8;
    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = CHAR_W + POS_W + DOC_W;

    localparam logic [CFG_IDX_W-1:0] CFG_DOC_ID       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_URL_MODE     = 2'd2;

    localparam logic [STY_W-1:0] STY_TITLE = 4'b0001;
    localparam logic [STY_W-1:0] STY_BOLD  = 4'b0010;
    localparam logic [STY_W-1:0] STY_HEAD  = 4'b0100;
    localparam logic [STY_W-1:0] STY_ITAL  = 4'b1000;

    localparam logic [CHAR_W-1:0] CH_LT    = 8'h3C;
    localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic              valid;
        logic [WLEN_W-1:0] len;
        logic [POS_W-1:0]  pos;
        logic [DOC_W-1:0]  doc;
        logic [STY_W-1:0]  sty;
    } t_flush;

    typedef struct packed {
        logic               we;
        logic [WADDR_W-1:0] addr;
        logic [CHAR_W-1:0]  data;
    } t_wr;

    typedef struct packed {
        logic             script;
        logic             closing;
        logic [STY_W-1:0] bits;
    } t_tag_act;

    function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_ws(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    // Decode the kept tag prefix; entries at or past cnt read as a space.
    function automatic t_tag_act decode_tag(
        input logic [TAG_PREFIX_LEN-1:0][CHAR_W-1:0] pfx,
        input logic [TCNT_W-1:0]                     cnt
    );
        logic [TAG_PREFIX_LEN-1:0][CHAR_W-1:0] t;
        logic [6:0][CHAR_W-1:0]                u;
        logic [CHAR_W-1:0]                     c;
        t_tag_act                              a;
        for (int k = 0; k < TAG_PREFIX_LEN; k++) begin
            t[k] = (TCNT_W'(k) < cnt) ? pfx[k] : CH_SPACE;
        end
        a = '0;
        a.closing = (t[0] == CH_SLASH);
        for (int k = 0; k < 7; k++) begin
            u[k] = a.closing ? t[k+1] : t[k];
        end
        c = fold(u[0]);
        if (c == "b" && is_ws(u[1])) begin
            a.bits = STY_BOLD;
        end else if (c == "i" && is_ws(u[1])) begin
            a.bits = STY_ITAL;
        end else if (c == "e" && fold(u[1]) == "m" && is_ws(u[2])) begin
            a.bits = STY_ITAL;
        end else if (c == "h" && u[1] >= "1" && u[1] <= "6" && is_ws(u[2])) begin
            a.bits = STY_HEAD;
        end else if (c == "t" && {fold(u[1]), fold(u[2]), fold(u[3]), fold(u[4])} == "itle"
                     && is_ws(u[5])) begin
            a.bits = STY_TITLE;
        end else if (c == "s" && is_ws(u[6]) &&
                     {fold(u[1]), fold(u[2]), fold(u[3]), fold(u[4]), fold(u[5])} == "trong") begin
            a.bits = STY_BOLD;
        end else if (c == "s" && is_ws(u[6]) &&
                     {fold(u[1]), fold(u[2]), fold(u[3]), fold(u[4]), fold(u[5])} == "cript") begin
            a.script = 1'b1;
        end
        return a;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/hwt_ram.sv
`default_nettype none
module hwt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/hwt_scan.sv
`default_nettype none
module hwt_scan (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [hwt_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [hwt_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                             i_acc,
    input  wire logic [hwt_pkg::CHAR_W-1:0]       i_byte,
    input  wire logic                             i_final,
    output hwt_pkg::t_flush                       o_flush,
    output hwt_pkg::t_wr                          o_wr
);
    import hwt_pkg::*;

    logic [DOC_W-1:0]  r_doc_id;
    logic [POS_W-1:0]  r_start_off;
    logic              r_url;

    logic [WLEN_W-1:0] r_len,    n_len;
    logic [POS_W-1:0]  r_start,  n_start;
    logic [POS_W-1:0]  r_bc,     n_bc;
    logic [TCNT_W-1:0] r_cnt,    n_cnt;
    logic              r_tag,    n_tag;
    logic              r_script, n_script;
    logic [STY_W-1:0]  r_style,  n_style;
    logic [TAG_PREFIX_LEN-1:0][CHAR_W-1:0] r_pfx, n_pfx;

    logic              w_alnum;
    logic              w_take;
    logic              w_pfx_room;
    logic [WLEN_W-1:0] w_len_upd;
    logic [POS_W-1:0]  w_start_upd;
    logic [WLEN_W-1:0] w_flen;
    t_tag_act          w_act;

    assign w_alnum    = is_alnum(i_byte);
    assign w_take     = w_alnum && (r_url || (!r_tag && !r_script));
    assign w_pfx_room = r_tag && (r_cnt < TCNT_W'(TAG_PREFIX_LEN));
    // length saturates one past the limit so an overlong word is dropped
    assign w_len_upd  = (w_take && r_len <= WLEN_W'(MAX_WORD_LEN)) ? r_len + WLEN_W'(1) : r_len;
    assign w_start_upd = (w_take && r_len == '0) ? r_bc : r_start;
    assign w_flen     = w_alnum ? w_len_upd : r_len;
    assign w_act      = decode_tag(r_pfx, r_cnt);

    // A word is emitted on a separator, or on the final byte of the document.
    assign o_flush.valid = i_acc && (!w_alnum || i_final) && (w_flen != '0)
                           && (w_flen <= WLEN_W'(MAX_WORD_LEN));
    assign o_flush.len   = w_flen;
    assign o_flush.pos   = r_url ? '0 : r_start_off + w_start_upd;
    assign o_flush.doc   = r_doc_id;
    assign o_flush.sty   = r_url ? '0 : r_style;

    assign o_wr.we   = i_acc && w_take && (r_len < WLEN_W'(MAX_WORD_LEN));
    assign o_wr.addr = r_len[WADDR_W-1:0];
    assign o_wr.data = fold(i_byte);

    always_comb begin
        n_len    = r_len;
        n_start  = r_start;
        n_bc     = r_bc;
        n_cnt    = r_cnt;
        n_tag    = r_tag;
        n_script = r_script;
        n_style  = r_style;
        n_pfx    = r_pfx;
        if (i_acc) begin
            if (w_alnum) begin
                n_len   = w_len_upd;
                n_start = w_start_upd;
                if (!w_take && w_pfx_room) begin
                    n_pfx[r_cnt[TIDX_W-1:0]] = i_byte;
                    n_cnt = r_cnt + TCNT_W'(1);
                end
            end else begin
                n_len = '0;
                if (!r_url) begin
                    if (i_byte == CH_LT) begin
                        n_tag = 1'b1;
                        n_cnt = '0;
                    end else if (i_byte == CH_GT) begin
                        if (r_tag) begin
                            n_tag = 1'b0;
                            if (w_act.script) begin
                                n_script = !w_act.closing;
                            end else if (w_act.closing) begin
                                n_style = r_style & ~w_act.bits;
                            end else begin
                                n_style = r_style | w_act.bits;
                            end
                        end
                    end else if (w_pfx_room) begin
                        n_pfx[r_cnt[TIDX_W-1:0]] = i_byte;
                        n_cnt = r_cnt + TCNT_W'(1);
                    end
                end
            end
            n_bc = r_bc + POS_W'(1);
            if (i_final) begin
                n_len    = '0;
                n_start  = '0;
                n_bc     = '0;
                n_cnt    = '0;
                n_tag    = 1'b0;
                n_script = 1'b0;
                n_style  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_doc_id    <= '0;
            r_start_off <= '0;
            r_url       <= 1'b0;
            r_len       <= '0;
            r_start     <= '0;
            r_bc        <= '0;
            r_cnt       <= '0;
            r_tag       <= 1'b0;
            r_script    <= 1'b0;
            r_style     <= '0;
        end else begin
            r_len    <= n_len;
            r_start  <= n_start;
            r_bc     <= n_bc;
            r_cnt    <= n_cnt;
            r_tag    <= n_tag;
            r_script <= n_script;
            r_style  <= n_style;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_DOC_ID:       r_doc_id    <= i_cfg_data[DOC_W-1:0];
                    CFG_START_OFFSET: r_start_off <= i_cfg_data[POS_W-1:0];
                    CFG_URL_MODE:     r_url       <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pfx <= n_pfx;
    end

endmodule
`default_nettype wire

FILE: rtl/hwt_emit.sv
`default_nettype none
module hwt_emit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire hwt_pkg::t_flush               i_flush,
    input  wire logic [hwt_pkg::CHAR_W-1:0]    i_rd_data,
    output logic      [hwt_pkg::WADDR_W-1:0]   o_rd_addr,
    output logic                               o_in_ready,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic      [hwt_pkg::CHAR_W-1:0]    o_char,
    output logic      [hwt_pkg::POS_W-1:0]     o_pos,
    output logic      [hwt_pkg::DOC_W-1:0]     o_doc,
    output logic      [hwt_pkg::STY_W-1:0]     o_sty,
    output logic                               o_last
);
    import hwt_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PRIME = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [WADDR_W-1:0] r_idx,   n_idx;
    logic [WLEN_W-1:0]  r_len;
    logic [POS_W-1:0]   r_pos;
    logic [DOC_W-1:0]   r_doc;
    logic [STY_W-1:0]   r_sty;
    logic               r_ovalid;

    logic w_ld;
    logic w_last;

    // output stage is free or being drained this cycle
    assign w_ld   = (r_state == ST_EMIT) && (!r_ovalid || i_out_ready);
    assign w_last = (WLEN_W'(r_idx) + WLEN_W'(1)) == r_len;

    // RAM read runs one entry ahead of the output stage
    assign o_rd_addr   = (w_ld && !w_last) ? r_idx + WADDR_W'(1) : r_idx;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_ovalid;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                if (i_flush.valid) begin
                    n_state = ST_PRIME;
                    n_idx   = '0;
                end
            end
            ST_PRIME: n_state = ST_EMIT;
            ST_EMIT: begin
                if (w_ld) begin
                    if (w_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx + WADDR_W'(1);
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (w_ld) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_flush.valid) begin
            r_len <= i_flush.len;
            r_pos <= i_flush.pos;
            r_doc <= i_flush.doc;
            r_sty <= i_flush.sty;
        end
        if (w_ld) begin
            o_char <= i_rd_data;
            o_pos  <= r_pos;
            o_doc  <= r_doc;
            o_sty  <= r_sty;
            o_last <= w_last;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/html_word_tokenizer.sv
`default_nettype none
// Splits a document body (or a URL) into lower-cased words of ASCII letters and
// digits, one input byte per item, skipping markup inside tags and script
// sections and tracking bold/italic/heading/title from the tags it sees. Each
// kept word leaves as one item per character carrying the word's position,
// the document number and the style bits, with tlast on its last character;
// words longer than MAX_WORD_LEN are dropped. A byte that ends no word leaves
// s_axis_tready high. A byte that ends a kept word holds s_axis_tready low
// while the word goes out: the word buffer's registered read port is primed
// first, then one character per cycle moves into the output register unless
// m_axis_tready stalls. The next byte can be taken while the last character
// still waits in the output register. The user is to write configuration
// only while no byte is in flight; the block itself does not enforce it.
module html_word_tokenizer (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [hwt_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [hwt_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [hwt_pkg::TDATA_IN_W-1:0]     s_axis_tdata,  // [7:0] in_byte
    input  wire logic                               s_axis_tlast,  // is_final
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [7:0] word_char, [39:8] word_position, [71:40] doc_number
    output logic      [hwt_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,
    output logic      [hwt_pkg::STY_W-1:0]          m_axis_tuser,  // [3:0] style_bits
    output logic                                    m_axis_tlast   // word_end
);
    import hwt_pkg::*;

    t_flush             w_flush;
    t_wr                w_wr;
    logic               w_acc;
    logic [WADDR_W-1:0] w_rd_addr;
    logic [CHAR_W-1:0]  w_rd_data;
    logic [CHAR_W-1:0]  w_char;
    logic [POS_W-1:0]   w_pos;
    logic [DOC_W-1:0]   w_doc;

    assign w_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tdata = {w_doc, w_pos, w_char};

    hwt_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_acc      (w_acc),
        .i_byte     (s_axis_tdata[CHAR_W-1:0]),
        .i_final    (s_axis_tlast),
        .o_flush    (w_flush),
        .o_wr       (w_wr)
    );

    hwt_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MAX_WORD_LEN),
        .AW    (WADDR_W)
    ) u_word_ram (
        .i_clk   (i_clk),
        .i_we    (w_wr.we),
        .i_waddr (w_wr.addr),
        .i_wdata (w_wr.data),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rd_data)
    );

    hwt_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_flush     (w_flush),
        .i_rd_data   (w_rd_data),
        .o_rd_addr   (w_rd_addr),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_char      (w_char),
        .o_pos       (w_pos),
        .o_doc       (w_doc),
        .o_sty       (m_axis_tuser),
        .o_last      (m_axis_tlast)
    );

endmodule
`default_nettype wire

FILE: rtl/hwt_checker.sv
`default_nettype none
`include "assert_macros.svh"
module hwt_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               s_axis_tready,
    input wire logic                               m_axis_tvalid,
    input wire logic                               m_axis_tready,
    input wire logic [hwt_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,
    input wire logic [hwt_pkg::STY_W-1:0]          m_axis_tuser,
    input wire logic                               m_axis_tlast
);
    import hwt_pkg::*;

    // a stalled item holds
    `HWT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled output item changed")

    // no new byte while a word is only partly out
    `HWT_ASSERT(a_no_take_mid_word, i_clk, i_rst_n, !(m_axis_tvalid && !m_axis_tlast && s_axis_tready), "input ready in the middle of a word")

    // characters of one word follow back to back and share position, doc and style
    `HWT_ASSERT_NEXT(a_word_fields, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && m_axis_tdata[TDATA_OUT_W-1:CHAR_W] == $past(m_axis_tdata[TDATA_OUT_W-1:CHAR_W]) && m_axis_tuser == $past(m_axis_tuser), "word fields broke within a word")

endmodule

bind html_word_tokenizer hwt_checker u_hwt_checker (.*);
`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 100ps
module testbench;
    import hwt_pkg::*;

    localparam int RUN_LIMIT     = 2_000_000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RX_LONG_HOLD  = 600;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic [POS_W-1:0]  pos;
        logic [DOC_W-1:0]  doc;
        logic [STY_W-1:0]  sty;
        logic              last;
    } t_word_char;

    // Tracks the tokenizer state byte by byte and holds the word characters still due.
    class word_tracker;
        logic [CHAR_W-1:0] word_buf [MAX_WORD_LEN];
        int unsigned       word_len;
        logic [POS_W-1:0]  word_at;
        logic [31:0]       bytes_seen;
        logic [CHAR_W-1:0] tag_buf [TAG_PREFIX_LEN];
        int unsigned       tag_len;
        bit                in_tag;
        bit                in_script;
        logic [STY_W-1:0]  style;
        logic [DOC_W-1:0]  doc_reg;
        logic [POS_W-1:0]  offset_reg;
        bit                url_reg;
        t_word_char        pending [$];
        int                errors;

        function new();
            word_len   = 0;
            word_at    = '0;
            bytes_seen = '0;
            tag_len    = 0;
            in_tag     = 0;
            in_script  = 0;
            style      = '0;
            doc_reg    = '0;
            offset_reg = '0;
            url_reg    = 0;
            errors     = 0;
        endfunction

        function bit is_word_byte(logic [7:0] c);
            return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function bit is_blank(logic [7:0] c);
            return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
        endfunction

        function logic [7:0] lower(logic [7:0] c);
            return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        endfunction

        function bit spells(input logic [7:0] t [16], input int at, input string s);
            for (int k = 0; k < s.len(); k++) begin
                if (lower(t[at+k]) != s[k]) return 0;
            end
            return is_blank(t[at+s.len()]);
        endfunction

        function void load(logic [DOC_W-1:0] doc, logic [POS_W-1:0] offs, bit url);
            doc_reg    = doc;
            offset_reg = offs;
            url_reg    = url;
        endfunction

        function void emit_word();
            t_word_char c;
            if (word_len >= 1 && word_len <= MAX_WORD_LEN) begin
                for (int k = 0; k < word_len; k++) begin
                    c.ch   = word_buf[k];
                    c.pos  = url_reg ? '0 : offset_reg + word_at;
                    c.doc  = doc_reg;
                    c.sty  = url_reg ? '0 : style;
                    c.last = (k == word_len - 1);
                    pending.insert(pending.size(), c);
                end
            end
            word_len = 0;
        endfunction

        // Closing '>' seen: unused prefix slots read as blanks.
        function void apply_tag();
            logic [7:0]       t [16];
            logic [7:0]       c;
            logic [STY_W-1:0] hit;
            bit               closing;
            bit               is_script;
            int               i;
            for (int k = 0; k < 16; k++) begin
                t[k] = (k < tag_len) ? tag_buf[k] : CH_SPACE;
            end
            closing   = (t[0] == CH_SLASH);
            i         = closing ? 1 : 0;
            c         = lower(t[i]);
            hit       = '0;
            is_script = 0;
            if (c == "b" || c == "i") begin
                if (is_blank(t[i+1])) hit = (c == "b") ? STY_BOLD : STY_ITAL;
            end else if (c == "e") begin
                if (lower(t[i+1]) == "m" && is_blank(t[i+2])) hit = STY_ITAL;
            end else if (c == "h") begin
                if (t[i+1] >= "1" && t[i+1] <= "6" && is_blank(t[i+2])) hit = STY_HEAD;
            end else if (c == "t") begin
                if (spells(t, i + 1, "itle")) hit = STY_TITLE;
            end else if (c == "s") begin
                if (spells(t, i + 1, "trong")) hit = STY_BOLD;
                else if (spells(t, i + 1, "cript")) is_script = 1;
            end
            if (is_script) begin
                in_script = !closing;
            end else if (hit != '0) begin
                if (closing) style &= ~hit;
                else style |= hit;
            end
        endfunction

        function void take_byte(logic [7:0] b, logic fin);
            if (is_word_byte(b)) begin
                if (url_reg || (!in_tag && !in_script)) begin
                    if (word_len == 0) word_at = bytes_seen;
                    if (word_len < MAX_WORD_LEN) word_buf[word_len] = lower(b);
                    if (word_len <= MAX_WORD_LEN) word_len++;
                end else if (in_tag && tag_len < TAG_PREFIX_LEN) begin
                    tag_buf[tag_len] = b;
                    tag_len++;
                end
            end else begin
                emit_word();
                if (!url_reg) begin
                    if (b == CH_LT) begin
                        in_tag  = 1;
                        tag_len = 0;
                    end else if (b == CH_GT) begin
                        if (in_tag) begin
                            apply_tag();
                            in_tag = 0;
                        end
                    end else if (in_tag && tag_len < TAG_PREFIX_LEN) begin
                        tag_buf[tag_len] = b;
                        tag_len++;
                    end
                end
            end
            bytes_seen++;
            if (fin) begin
                emit_word();
                word_at    = '0;
                bytes_seen = '0;
                tag_len    = 0;
                in_tag     = 0;
                in_script  = 0;
                style      = '0;
            end
        endfunction

        function void field_check(string what, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
            end
        endfunction

        function void check_char(logic [TDATA_OUT_W-1:0] data, logic [STY_W-1:0] user,
                                 logic last);
            t_word_char want;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected item: expected none, got data %0h user %0h last %0b",
                         $time, data, user, last);
                return;
            end
            want = pending.pop_front();
            field_check("word_char", 32'(want.ch), 32'(data[7:0]));
            field_check("word_position", want.pos, data[39:8]);
            field_check("doc_number", want.doc, data[71:40]);
            field_check("style_bits", 32'(want.sty), 32'(user));
            field_check("word_end", 32'(want.last), 32'(last));
        endfunction
    endclass

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx     = CFG_DOC_ID;
    logic [CFG_DATA_W-1:0]   i_cfg_data    = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [TDATA_IN_W-1:0]   s_axis_tdata  = '0;   // [7:0] in_byte
    logic                    s_axis_tlast  = 1'b0; // is_final
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [TDATA_OUT_W-1:0]  m_axis_tdata;         // [7:0] char, [39:8] position, [71:40] doc
    logic [STY_W-1:0]        m_axis_tuser;         // [3:0] style_bits
    logic                    m_axis_tlast;

    word_tracker tracker;
    bit          rx_hold_req = 1'b0;
    int          bytes_sent  = 0;
    int          cycle_count = 0;

    string tag_names [16] = '{"b", "i", "em", "h#", "title", "strong", "script", "s",
                              "em#", "titles", "bx", "p", "", "strongest", "h#x", "scripts"};
    int    long_lens [4]  = '{31, 32, 33, 45};
    string seps           = " .,;\n\t-!/";

    html_word_tokenizer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] mix_case(logic [7:0] c);
        if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) return c - 8'd32;
        return c;
    endfunction

    function automatic logic [7:0] rand_alnum();
        int r;
        r = $urandom_range(0, 61);
        if (r < 10) return 8'h30 + 8'(r);
        if (r < 36) return 8'h61 + 8'(r - 10);
        return 8'h41 + 8'(r - 36);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.take_byte(b, fin);
        bytes_sent++;
    endtask

    task automatic send_text(input string s, input bit fin_last);
        for (int k = 0; k < s.len(); k++) begin
            send_byte(s[k], fin_last && k == s.len() - 1);
        end
    endtask

    // One piece of page text: a word, a tag, blanks, noise or stray brackets.
    task automatic send_fragment(input bit end_doc);
        logic [7:0] frag [$];
        logic [7:0] ch;
        string      tname;
        int         r;
        int         n;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            n = ($urandom_range(0, 4) == 0) ? long_lens[$urandom_range(0, 3)]
                                            : $urandom_range(1, 8);
            repeat (n) frag.insert(frag.size(), rand_alnum());
            if ($urandom_range(0, 9) < 7) begin
                frag.insert(frag.size(), seps[$urandom_range(0, seps.len() - 1)]);
            end
        end else if (r < 65) begin
            frag.insert(frag.size(), CH_LT);
            if ($urandom_range(0, 1) == 1) frag.insert(frag.size(), CH_SLASH);
            tname = tag_names[$urandom_range(0, 15)];
            for (int k = 0; k < tname.len(); k++) begin
                ch = tname[k];
                if (ch == "#") ch = 8'h30 + 8'($urandom_range(0, 9));
                frag.insert(frag.size(), mix_case(ch));
            end
            if ($urandom_range(0, 9) < 3) begin
                frag.insert(frag.size(), ($urandom_range(0, 1) == 1) ? CH_SPACE : 8'd9);
                repeat ($urandom_range(1, 6)) frag.insert(frag.size(), rand_alnum());
                frag.insert(frag.size(), "=");
            end
            // an unclosed tag swallows the text that follows
            if ($urandom_range(0, 9) != 0) frag.insert(frag.size(), CH_GT);
        end else if (r < 75) begin
            r = $urandom_range(8, 13);
            frag.insert(frag.size(), (r == 8) ? CH_SPACE : 8'(r));
        end else if (r < 88) begin
            repeat ($urandom_range(1, 3)) frag.insert(frag.size(), 8'($urandom_range(0, 255)));
        end else begin
            r = $urandom_range(0, 2);
            if (r == 0) begin
                frag.insert(frag.size(), CH_GT);
            end else if (r == 1) begin
                frag.insert(frag.size(), CH_LT);
                frag.insert(frag.size(), CH_LT);
            end else begin
                frag.insert(frag.size(), CH_LT);
                frag.insert(frag.size(), CH_GT);
            end
        end
        foreach (frag[k]) send_byte(frag[k], end_doc && k == frag.size() - 1);
    endtask

    task automatic run_text(input int nbytes);
        int stop_at;
        stop_at = bytes_sent + nbytes;
        while (bytes_sent < stop_at) send_fragment($urandom_range(0, 14) == 0);
    endtask

    // Sender idle until every due character is out, then waits out the extra settle time.
    task automatic drain(input int extra);
        s_axis_tvalid <= 1'b0;
        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic load_regs(input logic [31:0] doc, input logic [31:0] offs, input bit url);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_DOC_ID;
        i_cfg_data <= doc;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_START_OFFSET;
        i_cfg_data <= offs;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_URL_MODE;
        i_cfg_data <= {31'b0, url};
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        tracker.load(doc, offs, url);
    endtask

    // Output side: random backpressure, plus one long hold on request.
    initial begin : rx_side
        int gap;
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (RX_LONG_HOLD) @(posedge i_clk);
            end
            gap = pick_gap();
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            tracker.check_char(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
    end

    initial begin : watchdog
        while (cycle_count < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("testbench: done, errors");
        $finish;
    end

    initial begin : main_seq
        tracker = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: tags, case folding, stray and nested brackets, byte extremes,
        // a word cut by the final byte
        load_regs('0, '0, 1'b0);
        send_text("<B>Az09 </b>>", 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_text("<<i>q", 1'b1);
        drain(SETTLE_CYCLES);

        // positions wrap; receiver stalls long so the input side backs up
        load_regs('1, 32'hFFFF_FFF0, 1'b0);
        rx_hold_req = 1'b1;
        run_text(100);
        drain(SETTLE_CYCLES);

        // URL mode picks up whatever word was left pending
        load_regs($urandom, $urandom, 1'b1);
        run_text(60);
        drain(SETTLE_CYCLES);

        load_regs($urandom, '0, 1'b0);
        run_text(50);
        drain(0);
        run_text(50);
        drain(SETTLE_CYCLES);

        load_regs('1, '1, 1'b1);
        run_text(50);
        drain(SETTLE_CYCLES);

        load_regs($urandom, $urandom, 1'b0);
        run_text(80);
        drain(SETTLE_CYCLES);

        if (tracker.errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
